// File: hdl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared widths, codes and state type for the piecewise-linear calibration
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

   localparam int MAX_POINTS_DEF = 16;

   localparam int KIND_W     = 2;
   localparam int PIDX_W     = 4;
   localparam int CODE_W     = 16;
   localparam int VPP_W      = 24;
   localparam int CNT_W      = 5;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // divider: quotient never reaches 2**DIV_STEPS
   localparam int DIV_STEPS  = 24;
   localparam int PROD_W     = VPP_W + CODE_W;
   localparam int DVD_W      = PROD_W + 2;
   localparam int DVS_W      = VPP_W + 1;
   localparam int DCNT_W     = 5;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_C2V   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_V2C   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EVAL,
      S_MUL,
      S_LOAD,
      S_DIV,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// File: hdl/piecewise_linear_calibration.sv
// ----------------------------------------------------------------------------
// piecewise_linear_calibration
// Calibration curve table with code-to-voltage and voltage-to-code lookup by
// linear interpolation; one shared restoring divider does the rounding divide.
// ----------------------------------------------------------------------------
// A write, an unused kind or a query on a bad point count is answered in the next
//   cycle, one input beat per cycle while the result side keeps up.
// A query scans point_count entries, one per cycle, then evaluates; on a failed
//   check or a flat segment it answers from there, else it first goes through multiply,
//   divider load and 24 divide steps. Input is ready again once the response slot is free.
// Reset (synchronous, active high) clears point_count, valid bits and result valid flag.
`default_nettype none

module piecewise_linear_calibration #(
   parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [plc_pkg::CNT_W-1:0]           csr_wr_data,   // point_count
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [plc_pkg::REQ_DATA_W-1:0]      req_tdata,     // point_index, code_in, vpp_in
   input  wire logic [plc_pkg::KIND_W-1:0]          req_tuser,     // kind
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [plc_pkg::RSP_DATA_W-1:0]           rsp_tdata,     // vpp_out, code_out
   output logic [plc_pkg::STATUS_W-1:0]             rsp_tuser      // status
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CODE_W = plc_pkg::CODE_W;
   localparam int VPP_W  = plc_pkg::VPP_W;
   localparam int CNT_W  = plc_pkg::CNT_W;
   localparam int NSTEP  = plc_pkg::DIV_STEPS;

   // input fields
   logic [plc_pkg::KIND_W-1:0] req_kind;
   logic [plc_pkg::PIDX_W-1:0] req_point_index;
   logic [CODE_W-1:0]          req_code_in;
   logic [VPP_W-1:0]           req_vpp_in;

   assign req_kind        = req_tuser;
   assign req_point_index = req_tdata[3:0];
   assign req_code_in     = req_tdata[19:4];
   assign req_vpp_in      = req_tdata[43:20];

   plc_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] last_ff;

   // point table
   logic [CODE_W-1:0] code_mem_ff [MAX_POINTS];
   logic [VPP_W-1:0]  vpp_mem_ff  [MAX_POINTS];
   logic              vld_ff      [MAX_POINTS];
   logic [CODE_W-1:0] code_rd_ff;
   logic [VPP_W-1:0]  vpp_rd_ff;
   logic              vld_rd_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic              wr_en;

   // scan registers
   logic [plc_pkg::KIND_W-1:0] kind_ff;
   logic [VPP_W-1:0]  key_ff;
   logic [VPP_W-1:0]  first_key_ff;
   logic [CODE_W-1:0] prev_c_ff, lo_c_ff, hi_c_ff;
   logic [VPP_W-1:0]  prev_v_ff, lo_v_ff, hi_v_ff;
   logic              found_ff;
   logic              bad_ff;

   // arithmetic registers
   logic [VPP_W-1:0]           mw_ff;
   logic [CODE_W-1:0]          mn_ff;
   logic [VPP_W-1:0]           den_ff;
   logic [VPP_W-1:0]           base_ff;
   logic [plc_pkg::PROD_W-1:0] prod_ff;
   logic [plc_pkg::DVS_W-1:0]  rem_ff;
   logic [plc_pkg::DVS_W-1:0]  dvs_ff;
   logic [NSTEP-1:0]           dvd_ff;
   logic [NSTEP-1:0]           q_ff;
   logic [plc_pkg::DCNT_W-1:0] div_cnt_ff;
   logic                       use_q_ff;
   logic [plc_pkg::STATUS_W-1:0] res_status_ff;
   logic [VPP_W-1:0]           res_vpp_ff;
   logic [CODE_W-1:0]          res_code_ff;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [plc_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [VPP_W-1:0]             rsp_vpp_ff;
   logic [CODE_W-1:0]            rsp_code_ff;

   // control and datapath nets
   logic              slot_free;
   logic              req_fire;
   logic              is_query;
   logic              cnt_ok;
   logic              start_scan;
   logic              imm_load;
   logic              done_load;
   logic              scan_last;
   logic              div_last;
   logic [CODE_W-1:0] cur_c;
   logic [VPP_W-1:0]  cur_v;
   logic [VPP_W-1:0]  cur_key;
   logic [VPP_W-1:0]  span;
   logic              range_err;
   logic              flat_seg;
   logic              eval_div;
   logic [plc_pkg::DVD_W-1:0] dividend;
   logic [plc_pkg::DVS_W:0]   trial;
   logic [plc_pkg::DVS_W:0]   diff;
   logic              q_bit;
   logic [VPP_W-1:0]  q_sum;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_query   = (req_kind == plc_pkg::KIND_C2V) || (req_kind == plc_pkg::KIND_V2C);
   assign cnt_ok     = (count_ff >= CNT_W'(2)) && (32'(count_ff) <= 32'(MAX_POINTS));
   assign start_scan = req_fire && is_query && cnt_ok;
   assign imm_load   = req_fire && !start_scan;
   assign scan_last  = (scan_ff == last_ff);
   assign div_last   = (div_cnt_ff == plc_pkg::DCNT_W'(NSTEP - 1));

   // entries never written read as zero
   assign cur_c   = vld_rd_ff ? code_rd_ff : '0;
   assign cur_v   = vld_rd_ff ? vpp_rd_ff  : '0;
   assign cur_key = (kind_ff == plc_pkg::KIND_C2V) ? VPP_W'(cur_c) : cur_v;

   assign span      = hi_v_ff - lo_v_ff;
   assign range_err = (key_ff < first_key_ff) || !found_ff;
   assign flat_seg  = (kind_ff == plc_pkg::KIND_V2C) && (span == '0);
   assign eval_div  = !bad_ff && !range_err && !flat_seg;

   assign dividend = {1'b0, prod_ff, 1'b0} + plc_pkg::DVD_W'(den_ff);
   assign trial    = {rem_ff, dvd_ff[NSTEP-1]};
   assign diff     = trial - {1'b0, dvs_ff};
   assign q_bit    = (trial >= {1'b0, dvs_ff});
   assign q_sum    = base_ff + q_ff;

   assign wr_en   = req_fire && (req_kind == plc_pkg::KIND_WRITE) &&
                    (32'(req_point_index) < 32'(MAX_POINTS));
   assign wr_addr = IDX_W'(req_point_index);

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plc_pkg::S_IDLE: begin
            if (start_scan) state_in = plc_pkg::S_SCAN;
         end
         plc_pkg::S_SCAN: begin
            if (scan_last) state_in = plc_pkg::S_EVAL;
         end
         plc_pkg::S_EVAL: begin
            state_in = eval_div ? plc_pkg::S_MUL : plc_pkg::S_DONE;
         end
         plc_pkg::S_MUL:  state_in = plc_pkg::S_LOAD;
         plc_pkg::S_LOAD: state_in = plc_pkg::S_DIV;
         plc_pkg::S_DIV: begin
            if (div_last) state_in = plc_pkg::S_DONE;
         end
         plc_pkg::S_DONE: begin
            if (slot_free) state_in = plc_pkg::S_IDLE;
         end
         default: state_in = plc_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      done_load  = 1'b0;
      scan_in    = scan_ff;
      rd_addr    = '0;
      unique case (state_ff)
         plc_pkg::S_IDLE: begin
            req_tready = slot_free;
            scan_in    = '0;
         end
         plc_pkg::S_SCAN: begin
            scan_in = scan_ff + CNT_W'(1);
            // prefetch the next entry while this one is checked
            if (!scan_last) rd_addr = IDX_W'(scan_ff + CNT_W'(1));
         end
         plc_pkg::S_DONE: begin
            done_load = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plc_pkg::S_IDLE;
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         if (csr_wr_en) count_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem_ff[wr_addr] <= req_code_in;
         vpp_mem_ff[wr_addr]  <= req_vpp_in;
      end
      code_rd_ff <= code_mem_ff[rd_addr];
      vpp_rd_ff  <= vpp_mem_ff[rd_addr];
      vld_rd_ff  <= vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_POINTS; i++) vld_ff[i] <= 1'b0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         plc_pkg::S_IDLE: begin
            if (req_fire) begin
               kind_ff  <= req_kind;
               key_ff   <= (req_kind == plc_pkg::KIND_C2V) ? VPP_W'(req_code_in) : req_vpp_in;
               last_ff  <= count_ff - CNT_W'(1);
               found_ff <= 1'b0;
               bad_ff   <= 1'b0;
            end
         end
         plc_pkg::S_SCAN: begin
            if (scan_ff == '0) begin
               first_key_ff <= cur_key;
            end else begin
               if ((cur_c <= prev_c_ff) || (cur_v < prev_v_ff)) bad_ff <= 1'b1;
               // keep the first segment whose upper end reaches the key
               if (!found_ff && (key_ff <= cur_key)) begin
                  found_ff <= 1'b1;
                  lo_c_ff  <= prev_c_ff;
                  lo_v_ff  <= prev_v_ff;
                  hi_c_ff  <= cur_c;
                  hi_v_ff  <= cur_v;
               end
            end
            prev_c_ff <= cur_c;
            prev_v_ff <= cur_v;
         end
         plc_pkg::S_EVAL: begin
            res_vpp_ff  <= '0;
            res_code_ff <= '0;
            use_q_ff    <= 1'b0;
            if (bad_ff) begin
               res_status_ff <= plc_pkg::ST_INVALID;
            end else if (range_err) begin
               res_status_ff <= plc_pkg::ST_RANGE;
            end else if (kind_ff == plc_pkg::KIND_C2V) begin
               res_status_ff <= plc_pkg::ST_OK;
               use_q_ff      <= 1'b1;
               mw_ff         <= span;
               mn_ff         <= key_ff[CODE_W-1:0] - lo_c_ff;
               den_ff        <= VPP_W'(hi_c_ff - lo_c_ff);
               base_ff       <= lo_v_ff;
            end else if (flat_seg) begin
               res_status_ff <= plc_pkg::ST_OK;
               res_code_ff   <= lo_c_ff;
            end else begin
               res_status_ff <= plc_pkg::ST_OK;
               use_q_ff      <= 1'b1;
               mw_ff         <= key_ff - lo_v_ff;
               mn_ff         <= hi_c_ff - lo_c_ff;
               den_ff        <= span;
               base_ff       <= VPP_W'(lo_c_ff);
            end
         end
         plc_pkg::S_MUL: begin
            prod_ff <= plc_pkg::PROD_W'(mw_ff) * plc_pkg::PROD_W'(mn_ff);
         end
         plc_pkg::S_LOAD: begin
            // quotient of (2*prod + den) / (2*den) rounds half up
            rem_ff     <= plc_pkg::DVS_W'(dividend[plc_pkg::DVD_W-1:NSTEP]);
            dvd_ff     <= dividend[NSTEP-1:0];
            dvs_ff     <= {den_ff, 1'b0};
            q_ff       <= '0;
            div_cnt_ff <= '0;
         end
         plc_pkg::S_DIV: begin
            rem_ff     <= q_bit ? diff[plc_pkg::DVS_W-1:0] : trial[plc_pkg::DVS_W-1:0];
            dvd_ff     <= {dvd_ff[NSTEP-2:0], 1'b0};
            q_ff       <= {q_ff[NSTEP-2:0], q_bit};
            div_cnt_ff <= div_cnt_ff + plc_pkg::DCNT_W'(1);
         end
         default: begin
            prod_ff <= prod_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (imm_load || done_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (imm_load) begin
         rsp_status_ff <= is_query ? plc_pkg::ST_INVALID : plc_pkg::ST_OK;
         rsp_vpp_ff    <= '0;
         rsp_code_ff   <= '0;
      end else if (done_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_vpp_ff    <= (use_q_ff && (kind_ff == plc_pkg::KIND_C2V)) ? q_sum : res_vpp_ff;
         rsp_code_ff   <= (use_q_ff && (kind_ff == plc_pkg::KIND_V2C)) ?
                          q_sum[CODE_W-1:0] : res_code_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_code_ff, rsp_vpp_ff};
   assign rsp_tuser  = rsp_status_ff;

   // ---------------------------------------------------------------- checks
   a_busy_after_query: assert property (@(posedge clock) disable iff (reset)
      start_scan |=> !req_tready)
      else $error("input still ready after starting a query");

   a_fail_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != plc_pkg::ST_OK)) |-> (rsp_tdata == '0))
      else $error("failed query carries nonzero data");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plc_pkg::S_SCAN) |-> (scan_ff <= last_ff))
      else $error("scan index ran past last point");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plc_pkg::S_DIV) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: dv/calibration_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calibration_checker
// Watches the request, response and CSR ports of the calibration block. It
// keeps its own copy of the curve table and point count, works out the
// response of every accepted request beat and compares each response beat
// field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------

module calibration_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [plc_pkg::CNT_W-1:0]        csr_wr_data,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [plc_pkg::REQ_DATA_W-1:0]   req_tdata,    // point_index, code_in, vpp_in
   input  wire logic [plc_pkg::KIND_W-1:0]       req_tuser,    // kind
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [plc_pkg::RSP_DATA_W-1:0]   rsp_tdata,    // vpp_out, code_out
   input  wire logic [plc_pkg::STATUS_W-1:0]     rsp_tuser,    // status
   output int                                    failures,
   output int                                    pending,
   output int                                    checked
);

   localparam int KIND_W         = plc_pkg::KIND_W;
   localparam int PIDX_W         = plc_pkg::PIDX_W;
   localparam int CODE_W         = plc_pkg::CODE_W;
   localparam int VPP_W          = plc_pkg::VPP_W;
   localparam int CNT_W          = plc_pkg::CNT_W;
   localparam int STATUS_W       = plc_pkg::STATUS_W;
   localparam int MAX_POINTS_DEF = plc_pkg::MAX_POINTS_DEF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VPP_W-1:0]    vpp;
      logic [CODE_W-1:0]   code;
   } cal_result_type;

   logic [CODE_W-1:0] curve_codes [MAX_POINTS_DEF];
   logic [VPP_W-1:0]  curve_volts [MAX_POINTS_DEF];
   logic [CNT_W-1:0]  active_count;
   cal_result_type    conversions_q [$];

   function automatic bit curve_valid();
      int i;
      if (active_count < 2 || active_count > MAX_POINTS_DEF) return 1'b0;
      for (i = 1; i < active_count; i++) begin
         if (curve_codes[i] <= curve_codes[i-1]) return 1'b0;
         if (curve_volts[i] < curve_volts[i-1]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // rounded lookup on the current table; writes and the spare kind give zeros
   function automatic cal_result_type convert(input logic [KIND_W-1:0] kind,
                                              input logic [CODE_W-1:0] code,
                                              input logic [VPP_W-1:0]  vpp);
      cal_result_type r;
      int             i, last;
      bit             found;
      logic [63:0]    lo_c, hi_c, lo_v, hi_v, prod, den;
      r     = '0;
      found = 1'b0;
      if (kind == plc_pkg::KIND_C2V || kind == plc_pkg::KIND_V2C) begin
         if (!curve_valid()) begin
            r.status = plc_pkg::ST_INVALID;
         end else begin
            last = active_count - 1;
            if (kind == plc_pkg::KIND_C2V) begin
               if (code < curve_codes[0] || code > curve_codes[last]) begin
                  r.status = plc_pkg::ST_RANGE;
               end else begin
                  for (i = 1; i <= last; i++) begin
                     if (!found && code <= curve_codes[i]) begin
                        found = 1'b1;
                        lo_c  = curve_codes[i-1];
                        hi_c  = curve_codes[i];
                        lo_v  = curve_volts[i-1];
                        hi_v  = curve_volts[i];
                        prod  = (64'(code) - lo_c) * (hi_v - lo_v);
                        den   = hi_c - lo_c;
                        r.vpp = VPP_W'(lo_v + (2 * prod + den) / (2 * den));
                     end
                  end
               end
            end else begin
               if (vpp < curve_volts[0] || vpp > curve_volts[last]) begin
                  r.status = plc_pkg::ST_RANGE;
               end else begin
                  for (i = 1; i <= last; i++) begin
                     if (!found && vpp <= curve_volts[i]) begin
                        found = 1'b1;
                        lo_c  = curve_codes[i-1];
                        hi_c  = curve_codes[i];
                        lo_v  = curve_volts[i-1];
                        hi_v  = curve_volts[i];
                        den   = hi_v - lo_v;
                        // flat segment: take its lower code
                        if (den == 0) begin
                           r.code = CODE_W'(lo_c);
                        end else begin
                           prod   = (64'(vpp) - lo_v) * (hi_c - lo_c);
                           r.code = CODE_W'(lo_c + (2 * prod + den) / (2 * den));
                        end
                     end
                  end
               end
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cal_result_type    want, got;
      int                i, errs;
      logic [PIDX_W-1:0] beat_idx;
      logic [CODE_W-1:0] beat_code;
      logic [VPP_W-1:0]  beat_vpp;
      errs      = 0;
      beat_idx  = req_tdata[0 +: PIDX_W];
      beat_code = req_tdata[PIDX_W +: CODE_W];
      beat_vpp  = req_tdata[PIDX_W + CODE_W +: VPP_W];
      if (reset) begin
         for (i = 0; i < MAX_POINTS_DEF; i++) begin
            curve_codes[i] = '0;
            curve_volts[i] = '0;
         end
         active_count = '0;
         conversions_q.delete();
         failures <= 0;
         pending  <= 0;
         checked  <= 0;
      end else begin
         if (csr_wr_en) active_count = csr_wr_data;
         if (req_tvalid && req_tready) begin
            conversions_q.push_back(convert(req_tuser, beat_code, beat_vpp));
            if (req_tuser == plc_pkg::KIND_WRITE) begin
               curve_codes[beat_idx] = beat_code;
               curve_volts[beat_idx] = beat_vpp;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.vpp    = rsp_tdata[0 +: VPP_W];
            got.code   = rsp_tdata[VPP_W +: CODE_W];
            if (conversions_q.size() == 0) begin
               $display("%0t: unexpected response beat status %0d vpp %h code %h",
                        $time, got.status, got.vpp, got.code);
               errs++;
            end else begin
               want = conversions_q.pop_front();
               if (got.status != want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, got.status);
                  errs++;
               end
               if (got.vpp != want.vpp) begin
                  $display("%0t: vpp_out mismatch: expected %h, actual %h",
                           $time, want.vpp, got.vpp);
                  errs++;
               end
               if (got.code != want.code) begin
                  $display("%0t: code_out mismatch: expected %h, actual %h",
                           $time, want.code, got.code);
                  errs++;
               end
               checked <= checked + 1;
            end
         end
         failures <= failures + errs;
         pending  <= conversions_q.size();
      end
   end

endmodule

// File: dv/piecewise_linear_calibration_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_test
// Drives the calibration block with directed curves and queries, then with
// random monotonic curves, broken curves and bad point counts under several
// pacing modes, including a long response stall. The checker next to the
// block predicts and compares every response.
// ----------------------------------------------------------------------------

module piecewise_linear_calibration_test;

   localparam int KIND_W         = plc_pkg::KIND_W;
   localparam int PIDX_W         = plc_pkg::PIDX_W;
   localparam int CODE_W         = plc_pkg::CODE_W;
   localparam int VPP_W          = plc_pkg::VPP_W;
   localparam int CNT_W          = plc_pkg::CNT_W;
   localparam int STATUS_W       = plc_pkg::STATUS_W;
   localparam int REQ_DATA_W     = plc_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W     = plc_pkg::RSP_DATA_W;
   localparam int MAX_POINTS_DEF = plc_pkg::MAX_POINTS_DEF;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int CODE_MAX       = (1 << CODE_W) - 1;
   localparam int VPP_MAX        = (1 << VPP_W) - 1;
   localparam int COUNT_MAX      = (1 << CNT_W) - 1;
   localparam int MODE_ITEMS     = 320;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [KIND_W-1:0]     req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   logic hold_go = 1'b0;
   int   hold_left = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   quiet_cycles = 0;
   int   items_sent = 0;
   int   queries_sent = 0;
   int   settings_used = 0;
   int   failures, pending_results, results_checked;

   always #5 clock = ~clock;

   piecewise_linear_calibration #(.MAX_POINTS(MAX_POINTS_DEF)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   calibration_checker lookup_check (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .failures   (failures),
      .pending    (pending_results),
      .checked    (results_checked)
   );

   // response side: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [PIDX_W-1:0] idx,
                            input logic [CODE_W-1:0] code, input logic [VPP_W-1:0] vpp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - PIDX_W - CODE_W - VPP_W){1'b0}}, vpp, code, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (kind == plc_pkg::KIND_C2V || kind == plc_pkg::KIND_V2C) queries_sent++;
   endtask

   // drop valid and wait until every response is back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   // one curve: set the count, write the points, then a burst of queries
   task automatic curve_session(input int force_n);
      int  n, cnt, q_total, r, j, room, step;
      bit  narrow_c, narrow_v;
      int  codes [MAX_POINTS_DEF];
      int  volts [MAX_POINTS_DEF];
      logic [CODE_W-1:0] qc;
      logic [VPP_W-1:0]  qv;
      logic [PIDX_W-1:0] qi;
      r = $urandom_range(0, 99);
      if (force_n != 0) n = force_n;
      else if (r < 60) n = $urandom_range(2, 4);
      else if (r < 85) n = $urandom_range(5, 10);
      else n = $urandom_range(11, MAX_POINTS_DEF);
      cnt = n;
      r = $urandom_range(0, 99);
      if (r < 6) cnt = $urandom_range(0, 1);
      else if (r < 12) cnt = $urandom_range(MAX_POINTS_DEF + 1, COUNT_MAX);
      settle();
      write_count(CNT_W'(cnt));

      narrow_c = ($urandom_range(0, 2) == 0);
      narrow_v = ($urandom_range(0, 2) == 0);
      codes[0] = narrow_c ? $urandom_range(0, CODE_MAX - 4 * n) : $urandom_range(0, CODE_MAX / 4);
      volts[0] = narrow_v ? $urandom_range(0, VPP_MAX - 4 * n) : $urandom_range(0, VPP_MAX / 4);
      if ($urandom_range(0, 7) == 0) codes[0] = 0;
      if ($urandom_range(0, 7) == 0) volts[0] = 0;
      for (j = 1; j < n; j++) begin
         room     = (CODE_MAX - codes[j-1]) / (n - j);
         step     = narrow_c ? $urandom_range(1, (room < 3) ? room : 3) : $urandom_range(1, room);
         codes[j] = codes[j-1] + step;
         room     = (VPP_MAX - volts[j-1]) / (n - j);
         step     = narrow_v ? $urandom_range(0, (room < 3) ? room : 3) : $urandom_range(0, room);
         if ($urandom_range(0, 4) == 0) step = 0;
         volts[j] = volts[j-1] + step;
      end
      if (!narrow_c && $urandom_range(0, 3) == 0) codes[n-1] = CODE_MAX;
      if (!narrow_v && $urandom_range(0, 3) == 0) volts[n-1] = VPP_MAX;
      for (j = 0; j < n; j++)
         send_item(plc_pkg::KIND_WRITE, PIDX_W'(j), CODE_W'(codes[j]), VPP_W'(volts[j]));

      q_total = $urandom_range(8, 24);
      for (j = 0; j < q_total; j++) begin
         r  = $urandom_range(0, 99);
         qc = CODE_W'($urandom_range(0, CODE_MAX));
         qv = VPP_W'($urandom_range(0, VPP_MAX));
         qi = PIDX_W'($urandom_range(0, MAX_POINTS_DEF - 1));
         if (r < 40) begin
            if ($urandom_range(0, 4) == 0) qc = CODE_W'(codes[$urandom_range(0, n - 1)]);
            else qc = CODE_W'($urandom_range(codes[0], codes[n-1]));
            send_item(plc_pkg::KIND_C2V, qi, qc, qv);
         end else if (r < 80) begin
            if ($urandom_range(0, 4) == 0) qv = VPP_W'(volts[$urandom_range(0, n - 1)]);
            else qv = VPP_W'($urandom_range(volts[0], volts[n-1]));
            send_item(plc_pkg::KIND_V2C, qi, qc, qv);
         end else if (r < 86) begin
            // just outside either end of the curve, or anywhere
            if ($urandom_range(0, 1) == 0)
               qc = ($urandom_range(0, 1) == 0) ? CODE_W'(codes[0] - 1) : CODE_W'(codes[n-1] + 1);
            send_item(plc_pkg::KIND_C2V, qi, qc, qv);
         end else if (r < 92) begin
            if ($urandom_range(0, 1) == 0)
               qv = ($urandom_range(0, 1) == 0) ? VPP_W'(volts[0] - 1) : VPP_W'(volts[n-1] + 1);
            send_item(plc_pkg::KIND_V2C, qi, qc, qv);
         end else if (r < 95) begin
            send_item(KIND_SPARE, qi, qc, qv);
         end else begin
            // stray point write, may break the curve
            send_item(plc_pkg::KIND_WRITE, qi, qc, qv);
         end
      end
   endtask

   initial begin
      pace_type pace;
      int       pi, mode_start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // spare kind and queries on an empty curve
      send_item(KIND_SPARE, 4'hF, 16'hFFFF, 24'hFFFFFF);
      send_item(plc_pkg::KIND_C2V, 4'h0, 16'h0000, 24'h000000);
      send_item(plc_pkg::KIND_V2C, 4'h0, 16'h0000, 24'h000000);
      // curve with a flat segment, a half-way tie and a full-scale top end
      send_item(plc_pkg::KIND_WRITE, 4'd0, 16'd10, 24'h000100);
      send_item(plc_pkg::KIND_WRITE, 4'd1, 16'd20, 24'h000100);
      send_item(plc_pkg::KIND_WRITE, 4'd2, 16'd22, 24'h000101);
      send_item(plc_pkg::KIND_WRITE, 4'd3, 16'd23, 24'h000103);
      send_item(plc_pkg::KIND_WRITE, 4'd4, 16'hFFFF, 24'hFFFFFF);
      send_item(plc_pkg::KIND_WRITE, 4'd15, 16'hFFFF, 24'hFFFFFF);
      settle();
      write_count(CNT_W'(5));
      send_item(plc_pkg::KIND_C2V, 4'd0, 16'd9, 24'h0);
      send_item(plc_pkg::KIND_C2V, 4'd0, 16'd10, 24'h0);
      send_item(plc_pkg::KIND_C2V, 4'd0, 16'd15, 24'h0);
      send_item(plc_pkg::KIND_C2V, 4'd0, 16'd21, 24'h0);
      send_item(plc_pkg::KIND_C2V, 4'd0, 16'h8000, 24'h0);
      send_item(plc_pkg::KIND_C2V, 4'd0, 16'hFFFF, 24'h0);
      send_item(plc_pkg::KIND_V2C, 4'd0, 16'h0, 24'h0000FF);
      send_item(plc_pkg::KIND_V2C, 4'd0, 16'h0, 24'h000100);
      send_item(plc_pkg::KIND_V2C, 4'd0, 16'h0, 24'h000102);
      send_item(plc_pkg::KIND_V2C, 4'd0, 16'h0, 24'h800000);
      send_item(plc_pkg::KIND_V2C, 4'd0, 16'h0, 24'hFFFFFF);
      // point counts past the table and too few points
      settle();
      write_count(CNT_W'(MAX_POINTS_DEF + 1));
      send_item(plc_pkg::KIND_C2V, 4'd0, 16'd100, 24'h0);
      settle();
      write_count(CNT_W'(COUNT_MAX));
      send_item(plc_pkg::KIND_V2C, 4'd0, 16'h0, 24'h000200);
      settle();
      write_count(CNT_W'(1));
      send_item(plc_pkg::KIND_C2V, 4'd0, 16'd10, 24'h0);
      // codes no longer increasing
      settle();
      write_count(CNT_W'(5));
      send_item(plc_pkg::KIND_WRITE, 4'd1, 16'd5, 24'h000100);
      send_item(plc_pkg::KIND_C2V, 4'd0, 16'd21, 24'h0);

      for (pi = 0; pi < 4; pi++) begin
         pace = pace_type'(pi);
         settle();
         case (pace)
            PACE_FULL: begin
               send_idle_pct  <= 0;
               recv_stall_pct <= 0;
            end
            PACE_SEND_GAPS: begin
               send_idle_pct  <= 55;
               recv_stall_pct <= 0;
            end
            PACE_RECV_STALLS: begin
               send_idle_pct  <= 0;
               recv_stall_pct <= 55;
            end
            default: begin
               send_idle_pct  <= 18;
               recv_stall_pct <= 18;
            end
         endcase
         @(posedge clock);
         if (pace == PACE_FULL) begin
            // hold responses off while requests keep coming
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         mode_start = items_sent;
         curve_session(MAX_POINTS_DEF);
         while (items_sent - mode_start < MODE_ITEMS) curve_session(0);
      end

      settle();
      repeat (64) @(posedge clock);
      $display("summary: %0d request beats (%0d queries) over %0d point-count settings",
               items_sent, queries_sent, settings_used);
      $display("summary: %0d responses checked, %0d mismatches", results_checked, failures);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
